// ----- design/rrd_pkg.sv -----
// Shared types, codes and command tables of the RESP request deframer.
package rrd_pkg;

   typedef enum logic [6:0] {
      PH_WAIT  = 7'b0000001,
      PH_COUNT = 7'b0000010,
      PH_LEAD  = 7'b0000100,
      PH_LEN   = 7'b0001000,
      PH_DATA  = 7'b0010000,
      PH_CR    = 7'b0100000,
      PH_LF    = 7'b1000000
   } phase_type;

   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_ARG   = 2'd1;
   localparam logic [1:0] EV_DONE  = 2'd2;
   localparam logic [1:0] EV_ERROR = 2'd3;

   localparam logic [1:0] ERR_LEAD   = 2'd0;
   localparam logic [1:0] ERR_NUMBER = 2'd1;
   localparam logic [1:0] ERR_LIMIT  = 2'd2;
   localparam logic [1:0] ERR_CRLF   = 2'd3;

   localparam logic [1:0] CLS_UNKNOWN = 2'd0;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam int LINE_BYTES = 127;
   localparam int CMD_COUNT  = 3;

   localparam logic CSR_MAX_ARGS = 1'b0;
   localparam logic CSR_MAX_LEN  = 1'b1;

   localparam logic [4:0]  MAX_ARGS_RESET = 5'd16;
   localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

   typedef struct packed {
      logic [4:0]  max_arguments;
      logic [15:0] max_argument_length;
   } rrd_cfg_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  payload_byte;
      logic [3:0]  argument_index;
      logic [15:0] argument_length;
      logic [4:0]  argument_count;
      logic [1:0]  command_class;
      logic [1:0]  error_cause;
   } rrd_result_type;

   // command k: 0 get, 1 set, 2 quit
   function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [1:0] pos);
      logic [7:0] c;
      c = 8'h00;
      unique case ({k, pos})
         4'b00_00: c = 8'h67;
         4'b00_01: c = 8'h65;
         4'b00_10: c = 8'h74;
         4'b01_00: c = 8'h73;
         4'b01_01: c = 8'h65;
         4'b01_10: c = 8'h74;
         4'b10_00: c = 8'h71;
         4'b10_01: c = 8'h75;
         4'b10_10: c = 8'h69;
         4'b10_11: c = 8'h74;
         default:  c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] cmd_len(input logic [1:0] k);
      return (k == 2'd2) ? 3'd4 : 3'd3;
   endfunction

   function automatic logic [4:0] cmd_argc(input logic [1:0] k);
      logic [4:0] n;
      n = 5'd0;
      unique case (k)
         2'd0:    n = 5'd2;
         2'd1:    n = 5'd3;
         2'd2:    n = 5'd1;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- design/rrd_csr.sv -----
// Configuration registers of the RESP request deframer behind the APB-style port.
module rrd_csr
   import rrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output rrd_cfg_type cfg
);

   logic [4:0]  max_args_ff;
   logic [15:0] max_len_ff;
   logic        wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff <= MAX_ARGS_RESET;
         max_len_ff  <= MAX_LEN_RESET;
      end else if (wr_en) begin
         if (paddr[2] == CSR_MAX_ARGS) begin
            max_args_ff <= pwdata[4:0];
         end else begin
            max_len_ff <= pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == CSR_MAX_ARGS) begin
         prdata = {27'd0, max_args_ff};
      end else begin
         prdata = {16'd0, max_len_ff};
      end
   end

   assign cfg.max_arguments       = max_args_ff;
   assign cfg.max_argument_length = max_len_ff;

endmodule

// ----- design/rrd_parser.sv -----
// Framing state and per-byte next-state and event logic of the RESP deframer.
module rrd_parser
   import rrd_pkg::*;
#(
   parameter int ARG_LIMIT   = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  rrd_cfg_type    cfg,
   input  logic           in_valid,
   input  logic [7:0]     rx_byte,
   input  logic           take,
   output logic           emit,
   output rrd_result_type result
);

   localparam int ARG_CAP    = (ARG_LIMIT < 31) ? ARG_LIMIT : 31;
   localparam int COUNT_BITS = $clog2(ARG_CAP + 1);
   localparam int ACC_W      = LENGTH_BITS + 1;
   localparam int MUL_W      = LENGTH_BITS + 5;
   localparam int CMP_W      = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;
   localparam logic [ACC_W-1:0] NUM_SAT = {1'b1, {LENGTH_BITS{1'b0}}};
   localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'((64'd1 << LENGTH_BITS) - 64'd1);

   phase_type               phase_ff, phase_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    started_ff, started_in;
   logic                    ended_ff, ended_in;
   logic                    cr_ff, cr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [COUNT_BITS-1:0]   arg_ff, arg_in;
   logic [LENGTH_BITS-1:0]  rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]  len_ff, len_in;
   logic [2:0]              match_ff, match_in;
   logic [2:0]              npos_ff, npos_in;

   logic                    is_digit, is_space, clear_req, go_count;
   logic [7:0]              digit, low;
   logic [MUL_W-1:0]        acc_mul;
   logic [ACC_W-1:0]        acc_sat;
   logic [ACC_W-1:0]        num_acc;
   logic                    num_started, num_ended, num_cr;
   logic                    num_ok, num_long;
   logic [LENGTH_BITS-1:0]  rem_inc;
   logic [ACC_W-1:0]        lim_cnt;
   logic [CMP_W-1:0]        lim_len, len_cfg;
   logic [COUNT_BITS:0]     arg_plus;
   logic [1:0]              cls;
   logic [2:0]              match_upd;
   logic [31:0]             arg_wide, len_wide;

   assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
   assign digit    = rx_byte - CH_ZERO;
   assign low      = ((rx_byte >= CH_UPPER_A) && (rx_byte <= CH_UPPER_Z)) ?
                     rx_byte + CASE_OFFSET : rx_byte;
   assign acc_mul  = (MUL_W'(acc_ff) << 3) + (MUL_W'(acc_ff) << 1) + MUL_W'(digit[3:0]);
   assign acc_sat  = (acc_mul > MUL_W'(NUM_SAT)) ? NUM_SAT : acc_mul[ACC_W-1:0];
   assign rem_inc  = rem_ff + LENGTH_BITS'(1);
   assign num_ok   = (rx_byte == CH_LF) && cr_ff;
   assign num_long = rem_inc >= LENGTH_BITS'(LINE_BYTES);

   // number line digit accumulation, skipping leading blanks and trailing junk
   always_comb begin
      num_acc     = acc_ff;
      num_started = started_ff;
      num_ended   = ended_ff;
      num_cr      = (rx_byte == CH_CR);
      if (!ended_ff) begin
         if (!started_ff) begin
            if (!is_space) begin
               num_started = 1'b1;
               if (is_digit) begin
                  num_acc = ACC_W'(digit[3:0]);
               end else if (rx_byte != CH_PLUS) begin
                  num_ended = 1'b1;
               end
            end
         end else if (is_digit) begin
            num_acc = acc_sat;
         end else begin
            num_ended = 1'b1;
         end
      end
   end

   assign lim_cnt  = (32'(cfg.max_arguments) < ARG_LIMIT) ?
                     ACC_W'(cfg.max_arguments) : ACC_W'(ARG_LIMIT);
   assign len_cfg  = CMP_W'(cfg.max_argument_length);
   assign lim_len  = (len_cfg > LEN_MAX) ? LEN_MAX : len_cfg;
   assign arg_plus = (COUNT_BITS + 1)'(arg_ff) + (COUNT_BITS + 1)'(1);

   always_comb begin
      match_upd = match_ff;
      for (int k = 0; k < CMD_COUNT; k++) begin
         if ((npos_ff >= cmd_len(2'(k))) || (cmd_char(2'(k), npos_ff[1:0]) != low)) begin
            match_upd[k] = 1'b0;
         end
      end
   end

   always_comb begin
      cls = CLS_UNKNOWN;
      for (int k = CMD_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k] && (npos_ff == cmd_len(2'(k))) &&
             (5'(count_ff) == cmd_argc(2'(k)))) begin
            cls = 2'(k + 1);
         end
      end
   end

   assign arg_wide = 32'(arg_ff);
   assign len_wide = 32'(len_ff);

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      started_in = started_ff;
      ended_in   = ended_ff;
      cr_in      = cr_ff;
      count_in   = count_ff;
      arg_in     = arg_ff;
      rem_in     = rem_ff;
      len_in     = len_ff;
      match_in   = match_ff;
      npos_in    = npos_ff;
      clear_req  = 1'b0;
      go_count   = 1'b0;
      emit       = 1'b0;

      result.event_kind      = EV_DATA;
      result.payload_byte    = 8'd0;
      result.argument_index  = arg_wide[3:0];
      result.argument_length = len_wide[15:0];
      result.argument_count  = 5'(count_ff);
      result.command_class   = CLS_UNKNOWN;
      result.error_cause     = ERR_LEAD;

      unique case (phase_ff)
         PH_COUNT, PH_LEN: begin
            rem_in     = rem_inc;
            acc_in     = num_acc;
            started_in = num_started;
            ended_in   = num_ended;
            cr_in      = num_cr;
            if (num_ok) begin
               acc_in     = acc_ff;
               started_in = started_ff;
               ended_in   = ended_ff;
               cr_in      = cr_ff;
               if (acc_ff == '0) begin
                  emit = 1'b1;
                  result.event_kind  = EV_ERROR;
                  result.error_cause = ERR_NUMBER;
                  clear_req = 1'b1;
               end else if (phase_ff == PH_COUNT) begin
                  if (acc_ff > lim_cnt) begin
                     emit = 1'b1;
                     result.event_kind  = EV_ERROR;
                     result.error_cause = ERR_LIMIT;
                     clear_req = 1'b1;
                  end else begin
                     count_in = acc_ff[COUNT_BITS-1:0];
                     arg_in   = '0;
                     match_in = 3'b111;
                     npos_in  = 3'd0;
                     phase_in = PH_LEAD;
                  end
               end else begin
                  if (CMP_W'(acc_ff) > lim_len) begin
                     emit = 1'b1;
                     result.event_kind  = EV_ERROR;
                     result.error_cause = ERR_LIMIT;
                     clear_req = 1'b1;
                  end else begin
                     len_in   = acc_ff[LENGTH_BITS-1:0];
                     rem_in   = acc_ff[LENGTH_BITS-1:0];
                     phase_in = PH_DATA;
                  end
               end
            end else if (num_long) begin
               emit = 1'b1;
               result.event_kind  = EV_ERROR;
               result.error_cause = ERR_CRLF;
               clear_req = 1'b1;
            end
         end
         PH_LEAD: begin
            if (rx_byte != CH_DOLLAR) begin
               emit = 1'b1;
               result.event_kind  = EV_ERROR;
               result.error_cause = ERR_LEAD;
               clear_req = 1'b1;
            end else begin
               acc_in     = '0;
               started_in = 1'b0;
               ended_in   = 1'b0;
               cr_in      = 1'b0;
               rem_in     = '0;
               phase_in   = PH_LEN;
            end
         end
         PH_DATA: begin
            if (arg_ff == '0) begin
               match_in = match_upd;
               if (npos_ff != 3'd7) begin
                  npos_in = npos_ff + 3'd1;
               end
            end
            emit = 1'b1;
            result.event_kind   = EV_DATA;
            result.payload_byte = rx_byte;
            if (rem_ff != '0) begin
               rem_in = rem_ff - LENGTH_BITS'(1);
            end
            if ((rem_ff == '0) || (rem_ff == LENGTH_BITS'(1))) begin
               phase_in = PH_CR;
            end
         end
         PH_CR: begin
            if (rx_byte != CH_CR) begin
               emit = 1'b1;
               result.event_kind  = EV_ERROR;
               result.error_cause = ERR_CRLF;
               clear_req = 1'b1;
            end else begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            emit = 1'b1;
            if (rx_byte != CH_LF) begin
               result.event_kind  = EV_ERROR;
               result.error_cause = ERR_CRLF;
               clear_req = 1'b1;
            end else if (arg_plus >= (COUNT_BITS + 1)'(count_ff)) begin
               result.event_kind    = EV_DONE;
               result.command_class = cls;
               clear_req = 1'b1;
            end else begin
               result.event_kind = EV_ARG;
               arg_in   = arg_plus[COUNT_BITS-1:0];
               phase_in = PH_LEAD;
            end
         end
         default: begin
            if (rx_byte != CH_STAR) begin
               emit = 1'b1;
               result.event_kind  = EV_ERROR;
               result.error_cause = ERR_LEAD;
            end else begin
               go_count = 1'b1;
            end
            clear_req = 1'b1;
         end
      endcase

      if (clear_req) begin
         phase_in   = go_count ? PH_COUNT : PH_WAIT;
         acc_in     = '0;
         started_in = 1'b0;
         ended_in   = 1'b0;
         cr_in      = 1'b0;
         count_in   = '0;
         arg_in     = '0;
         rem_in     = '0;
         len_in     = '0;
         match_in   = 3'b111;
         npos_in    = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT;
         acc_ff     <= '0;
         started_ff <= 1'b0;
         ended_ff   <= 1'b0;
         cr_ff      <= 1'b0;
         count_ff   <= '0;
         arg_ff     <= '0;
         rem_ff     <= '0;
         len_ff     <= '0;
         match_ff   <= 3'b111;
         npos_ff    <= 3'd0;
      end else if (take && in_valid) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         started_ff <= started_in;
         ended_ff   <= ended_in;
         cr_ff      <= cr_in;
         count_ff   <= count_in;
         arg_ff     <= arg_in;
         rem_ff     <= rem_in;
         len_ff     <= len_in;
         match_ff   <= match_in;
         npos_ff    <= npos_in;
      end
   end

endmodule

// ----- design/resp_request_deframer.sv -----
// Top level of the RESP request deframer: input and result registers around the parser.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_rx_byte
//   rsp      out        rsp_valid/rsp_stall  event, byte, index, length, count, class, cause
//   csr      in         psel/penable/pready  paddr, pwdata, prdata
//
// One byte per cycle sustained while no stalled result blocks it; a byte's event goes
// from the input register through the parser logic into the result register.
// Reset is synchronous and clears the framing state and both valid flags.
// A stalled result holds the result register; the input register still takes a byte
// that gives no event, and otherwise req_stall rises until the result moves on.
module resp_request_deframer
   import rrd_pkg::*;
#(
   parameter int ARG_LIMIT   = 16,
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_argument_index,
   output logic [15:0] rsp_argument_length,
   output logic [4:0]  rsp_argument_count,
   output logic [1:0]  rsp_command_class,
   output logic [1:0]  rsp_error_cause,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   rrd_cfg_type    cfg;
   rrd_result_type result;
   rrd_result_type rsp_ff;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           rsp_valid_ff;
   logic           emit;
   logic           take;

   rrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rrd_parser #(
      .ARG_LIMIT   (ARG_LIMIT),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (in_valid_ff),
      .rx_byte  (in_byte_ff),
      .take     (take),
      .emit     (emit),
      .result   (result)
   );

   assign take      = in_valid_ff && (!emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (take && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = rsp_ff.event_kind;
   assign rsp_payload_byte    = rsp_ff.payload_byte;
   assign rsp_argument_index  = rsp_ff.argument_index;
   assign rsp_argument_length = rsp_ff.argument_length;
   assign rsp_argument_count  = rsp_ff.argument_count;
   assign rsp_command_class   = rsp_ff.command_class;
   assign rsp_error_cause     = rsp_ff.error_cause;

`ifndef SYNTHESIS
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall raised with empty input register");

   a_event_lands: assert property (@(posedge clock) disable iff (reset)
      (take && emit) |=> rsp_valid_ff)
      else $error("event lost on its way to the result register");

   a_class_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_kind != EV_DONE)) |-> (rsp_ff.command_class == CLS_UNKNOWN))
      else $error("command class on a non-done event");

   a_cause_only_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_kind != EV_ERROR)) |-> (rsp_ff.error_cause == ERR_LEAD))
      else $error("error cause on a non-error event");

   a_payload_only_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.event_kind != EV_DATA)) |-> (rsp_ff.payload_byte == 8'd0))
      else $error("payload byte on a non-data event");
`endif

endmodule

// ----- bench/tb_resp_request_deframer.sv -----
// Self-checking testbench of the RESP request deframer: random byte streams against a predictor.
module tb_resp_request_deframer
   import rrd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_CAP    = 16;
   localparam int PHASE_ITEMS  = 175;
   localparam int PHASES       = 7;
   localparam int DRAIN_CYCLES = 4;

   localparam logic [2:0] ADDR_MAX_ARGS = {CSR_MAX_ARGS, 2'b00};
   localparam logic [2:0] ADDR_MAX_LEN  = {CSR_MAX_LEN, 2'b00};
   localparam logic [1:0] NO_CAUSE      = 2'd0;

   class deframe_scoreboard;
      typedef enum int {LINE_MORE, LINE_OK, LINE_NOCRLF} line_status_type;
      localparam int NUM_SAT = 65536;

      logic [4:0]  max_args;
      logic [15:0] max_len;
      phase_type   phase;
      int          acc;
      bit          started, ended, saw_cr;
      int          dcount, cur_arg, remaining, cur_len, name_pos;
      bit [2:0]    name_hits;
      string       cmd_names[3];
      int          cmd_argc[3];
      rrd_result_type pending_events[$];
      int          failures;
      int          checked;

      function new();
         cmd_names = '{"get", "set", "quit"};
         cmd_argc  = '{2, 3, 1};
         max_args  = MAX_ARGS_RESET;
         max_len   = MAX_LEN_RESET;
         failures  = 0;
         checked   = 0;
         clear_request();
      endfunction

      function void set_register(logic idx, int val);
         if (idx == CSR_MAX_ARGS) max_args = 5'(val);
         else max_len = 16'(val);
      endfunction

      function void clear_request();
         phase     = PH_WAIT;
         acc       = 0;
         started   = 0;
         ended     = 0;
         saw_cr    = 0;
         dcount    = 0;
         cur_arg   = 0;
         remaining = 0;
         cur_len   = 0;
         name_hits = 3'b111;
         name_pos  = 0;
      endfunction

      function void start_number();
         acc       = 0;
         started   = 0;
         ended     = 0;
         saw_cr    = 0;
         remaining = 0;
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] pay, logic [1:0] cls, logic [1:0] cause);
         rrd_result_type r;
         r.event_kind      = kind;
         r.payload_byte    = pay;
         r.argument_index  = 4'(cur_arg);
         r.argument_length = 16'(cur_len);
         r.argument_count  = 5'(dcount);
         r.command_class   = cls;
         r.error_cause     = cause;
         pending_events.push_back(r);
      endfunction

      function void abort(logic [1:0] cause);
         emit(EV_ERROR, 8'h00, CLS_UNKNOWN, cause);
         clear_request();
      endfunction

      function line_status_type number_byte(logic [7:0] b);
         bit was_cr;
         bit digit;
         was_cr = saw_cr;
         remaining++;
         if (b == CH_LF && was_cr) return LINE_OK;
         saw_cr = (b == CH_CR);
         if (!ended) begin
            digit = (b >= CH_ZERO && b <= CH_NINE);
            if (!started) begin
               if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
                  started = 1;
                  if (digit) acc = b - CH_ZERO;
                  else if (b != CH_PLUS) ended = 1;
               end
            end else if (digit) begin
               acc = acc * 10 + (b - CH_ZERO);
               if (acc > NUM_SAT) acc = NUM_SAT;
            end else begin
               ended = 1;
            end
         end
         if (remaining >= LINE_BYTES) return LINE_NOCRLF;
         return LINE_MORE;
      endfunction

      function void match_name(logic [7:0] b);
         logic [7:0] low;
         low = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
         for (int k = 0; k < CMD_COUNT; k++) begin
            if (name_pos >= cmd_names[k].len() || cmd_names[k][name_pos] != low)
               name_hits[k] = 1'b0;
         end
         if (name_pos < 7) name_pos++;
      endfunction

      function logic [1:0] command_of();
         for (int k = 0; k < CMD_COUNT; k++) begin
            if (name_hits[k] && name_pos == cmd_names[k].len() && dcount == cmd_argc[k])
               return 2'(k + 1);
         end
         return CLS_UNKNOWN;
      endfunction

      function void note_byte(logic [7:0] b);
         line_status_type st;
         int lim;
         case (phase)
            PH_COUNT, PH_LEN: begin
               st = number_byte(b);
               if (st == LINE_MORE) return;
               if (st == LINE_NOCRLF) begin
                  abort(ERR_CRLF);
                  return;
               end
               if (acc == 0) begin
                  abort(ERR_NUMBER);
                  return;
               end
               if (phase == PH_COUNT) begin
                  lim = (max_args < COUNT_CAP) ? max_args : COUNT_CAP;
                  if (acc > lim) begin
                     abort(ERR_LIMIT);
                     return;
                  end
                  dcount    = acc;
                  cur_arg   = 0;
                  name_hits = 3'b111;
                  name_pos  = 0;
                  phase     = PH_LEAD;
               end else begin
                  lim = max_len;
                  if (acc > lim) begin
                     abort(ERR_LIMIT);
                     return;
                  end
                  cur_len   = acc;
                  remaining = cur_len;
                  phase     = PH_DATA;
               end
            end
            PH_LEAD: begin
               if (b != CH_DOLLAR) begin
                  abort(ERR_LEAD);
               end else begin
                  start_number();
                  phase = PH_LEN;
               end
            end
            PH_DATA: begin
               if (cur_arg == 0) match_name(b);
               emit(EV_DATA, b, CLS_UNKNOWN, NO_CAUSE);
               if (remaining > 0) remaining--;
               if (remaining == 0) phase = PH_CR;
            end
            PH_CR: begin
               if (b != CH_CR) abort(ERR_CRLF);
               else phase = PH_LF;
            end
            PH_LF: begin
               if (b != CH_LF) begin
                  abort(ERR_CRLF);
               end else if (cur_arg + 1 >= dcount) begin
                  emit(EV_DONE, 8'h00, command_of(), NO_CAUSE);
                  clear_request();
               end else begin
                  emit(EV_ARG, 8'h00, CLS_UNKNOWN, NO_CAUSE);
                  cur_arg++;
                  phase = PH_LEAD;
               end
            end
            default: begin
               if (b != CH_STAR) begin
                  abort(ERR_LEAD);
               end else begin
                  clear_request();
                  start_number();
                  phase = PH_COUNT;
               end
            end
         endcase
      endfunction

      task report(string msg);
         failures++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("event %0d %s: got %0d, expected %0d", checked, name, got, want));
      endtask

      task check_result(rrd_result_type got);
         rrd_result_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected event kind %0d", got.event_kind));
         end else begin
            want = pending_events.pop_front();
            compare_field("event_kind", got.event_kind, want.event_kind);
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("argument_index", got.argument_index, want.argument_index);
            compare_field("argument_length", got.argument_length, want.argument_length);
            compare_field("argument_count", got.argument_count, want.argument_count);
            compare_field("command_class", got.command_class, want.command_class);
            compare_field("error_cause", got.error_cause, want.error_cause);
         end
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_argument_index;
   logic [15:0] rsp_argument_length;
   logic [4:0]  rsp_argument_count;
   logic [1:0]  rsp_command_class;
   logic [1:0]  rsp_error_cause;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   deframe_scoreboard ledger = new();
   logic [7:0] byte_stream[$];
   bit         no_idle;

   resp_request_deframer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_argument_index (rsp_argument_index),
      .rsp_argument_length(rsp_argument_length),
      .rsp_argument_count (rsp_argument_count),
      .rsp_command_class  (rsp_command_class),
      .rsp_error_cause    (rsp_error_cause),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------- stream building ----------------

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
      return v;
   endfunction

   function automatic logic [7:0] mixed_case(logic [7:0] c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - CASE_OFFSET;
      return c;
   endfunction

   function automatic void push_number(int value, bit decorate);
      if (decorate) begin
         repeat ($urandom_range(0, 2))
            byte_stream.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
         if ($urandom_range(0, 1) == 1) byte_stream.push_back(CH_PLUS);
      end
      push_text($sformatf("%0d", value));
      if (decorate && $urandom_range(0, 1) == 1)
         push_text(($urandom_range(0, 1) == 1) ? "x7" : " ;");
      push_text("\r\n");
   endfunction

   function automatic void push_argument(logic [7:0] data[$]);
      byte_stream.push_back(CH_DOLLAR);
      push_number(data.size(), $urandom_range(0, 3) == 0);
      foreach (data[i]) byte_stream.push_back(data[i]);
      push_text("\r\n");
   endfunction

   function automatic void push_request(int arg_lim, int len_lim);
      string      mangled[7];
      string      name;
      logic [7:0] arg[$];
      int         flavor, choice, n, eff, len_cap;
      mangled = '{"ge", "gett", "sets", "qui", "quitx", "g", "getset"};
      eff     = (arg_lim < 1) ? 1 : ((arg_lim > COUNT_CAP) ? COUNT_CAP : arg_lim);
      len_cap = (len_lim < 1) ? 1 : ((len_lim > 6) ? 6 : len_lim);
      flavor  = $urandom_range(0, 99);
      if (flavor < 70) begin
         choice = $urandom_range(0, 5);
         n = $urandom_range(1, (eff > 4) ? 4 : eff);
         if ($urandom_range(0, 29) == 0) n = eff;
         name = "";
         if (choice < CMD_COUNT) begin
            name = ledger.cmd_names[choice];
            if ($urandom_range(0, 4) != 0) n = ledger.cmd_argc[choice];
         end else if (choice == CMD_COUNT) begin
            name = mangled[$urandom_range(0, 6)];
         end
         byte_stream.push_back(CH_STAR);
         push_number(n, $urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) begin
            arg.delete();
            if (i == 0 && name.len() > 0) begin
               for (int j = 0; j < name.len(); j++) arg.push_back(mixed_case(name[j]));
            end else begin
               repeat ($urandom_range(1, len_cap)) arg.push_back(8'($urandom_range(0, 255)));
            end
            push_argument(arg);
         end
      end else begin
         case ($urandom_range(0, 8))
            0: push_text(($urandom_range(0, 1) == 1) ? "*0\r\n" : "*+0\r\n");
            1: begin
               byte_stream.push_back(CH_STAR);
               if ($urandom_range(0, 1) == 1) push_number(eff + 1 + $urandom_range(0, 3), 0);
               else push_number(99999999, 1);
            end
            2: begin
               case ($urandom_range(0, 3))
                  0: push_text("*-2\r\n");
                  1: push_text("*abc\r\n");
                  2: push_text("*\r\n");
                  default: push_text("* +\r\n");
               endcase
            end
            3: begin
               push_text("*1\r\n");
               byte_stream.push_back(any_but(CH_DOLLAR, CH_DOLLAR));
            end
            4: begin
               push_text("*1\r\n$2\r\n");
               repeat (2) byte_stream.push_back(8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1) == 1) begin
                  byte_stream.push_back(any_but(CH_CR, CH_CR));
               end else begin
                  byte_stream.push_back(CH_CR);
                  byte_stream.push_back(any_but(CH_LF, CH_LF));
               end
            end
            5: begin
               push_text("*1\r\n$");
               case ($urandom_range(0, 2))
                  0: push_text("0\r\n");
                  1: push_number((len_lim < 65535) ? len_lim + 1 : 70000, 0);
                  default: push_number(123456789, 1);
               endcase
            end
            6: begin
               if ($urandom_range(0, 3) == 0) begin
                  byte_stream.push_back(CH_STAR);
                  repeat (LINE_BYTES) byte_stream.push_back(any_but(CH_CR, CH_LF));
               end else if ($urandom_range(0, 1) == 1) begin
                  push_text("*1\r\r\n$1\r\nA\r\n");
               end else begin
                  push_text("*1\n\r\n$1\r\nz\r\n");
               end
            end
            7: repeat ($urandom_range(1, 4)) byte_stream.push_back(8'($urandom_range(0, 255)));
            default: push_text("*2\r\n$3\r\nset\r\n");
         endcase
      end
   endfunction

   // ---------------- drivers ----------------

   task send_byte(logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_byte(b);
   endtask

   task csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task csr_check(logic [2:0] addr, logic [31:0] want);
      logic [31:0] got;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = addr;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== want)
         ledger.report($sformatf("register at %0d reads %0d, expected %0d", addr, got, want));
   endtask

   task wait_drained();
      while (ledger.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random stall, then take one transfer and check it
   initial begin
      int hold;
      rrd_result_type got;
      rsp_stall = 1'b0;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 5);
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock);
         while (reset !== 1'b0 || rsp_valid !== 1'b1 || rsp_stall !== 1'b0);
         got = {rsp_event_kind, rsp_payload_byte, rsp_argument_index, rsp_argument_length,
                rsp_argument_count, rsp_command_class, rsp_error_cause};
         ledger.check_result(got);
      end
   end

   initial begin
      int phase_args[PHASES];
      int phase_len[PHASES];
      int wait_count;
      phase_args  = '{MAX_ARGS_RESET, 1, 31, 0, 3, 5, 0};
      phase_len   = '{MAX_LEN_RESET, 1, 65535, 0, 12, 300, 0};
      phase_args[PHASES-1] = $urandom_range(1, 16);
      phase_len[PHASES-1]  = $urandom_range(1, 65535);
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      no_idle     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            csr_write(ADDR_MAX_ARGS, phase_args[p]);
            ledger.set_register(CSR_MAX_ARGS, phase_args[p]);
            csr_write(ADDR_MAX_LEN, phase_len[p]);
            ledger.set_register(CSR_MAX_LEN, phase_len[p]);
            csr_check(ADDR_MAX_ARGS, phase_args[p]);
            csr_check(ADDR_MAX_LEN, phase_len[p]);
         end
         no_idle = (p == 2);
         byte_stream.delete();
         if (p == 0) begin
            // extremes of the byte, a mixed-case quit, zero count, missing dollar
            byte_stream.push_back(8'h00);
            byte_stream.push_back(8'hFF);
            push_text("*1\r\n$4\r\nquIT\r\n");
            push_text("*0\r\n");
            push_text("*1\r\n#");
         end
         while (byte_stream.size() < PHASE_ITEMS) push_request(phase_args[p], phase_len[p]);
         foreach (byte_stream[i]) send_byte(byte_stream[i]);
         @(negedge clock);
         req_valid = 1'b0;
      end

      wait_count = 0;
      while (ledger.pending_events.size() != 0 && wait_count < 2000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (8) @(posedge clock);
      if (ledger.pending_events.size() != 0)
         ledger.report($sformatf("%0d expected events never arrived",
                                 ledger.pending_events.size()));
      if (ledger.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
